### hdl/cfsf_pkg.sv
// Shared widths, register codes, tap control type and saturation helpers.
`timescale 1ns / 1ps

package cfsf_pkg;

    localparam int TAP_COUNT = 11;
    localparam int CENTER    = (TAP_COUNT - 1) / 2;
    localparam int NUM_COEF  = 6;

    localparam int SAMPLE_W  = 32;
    localparam int GAIN_W    = 40;
    localparam int WEIGHT_W  = 40;
    localparam int COEF_W    = 18;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 40;

    localparam int MLO_W     = SAMPLE_W + FRAC_W + 1;
    localparam int MHI_W     = SAMPLE_W + GAIN_W - FRAC_W;
    localparam int CAL_W     = MHI_W + 1;
    localparam int PROD_W    = WEIGHT_W + COEF_W;
    localparam int ACC_W     = PROD_W + $clog2(TAP_COUNT);
    localparam int RND_W     = ACC_W + 1;
    localparam int CNT_W     = $clog2(TAP_COUNT);

    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SIDE1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SIDE2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SIDE3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SIDE4  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SIDE5  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET  = 3'd7;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    typedef struct packed {
        logic load;
        logic shift;
    } tap_ctl_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] val;
        logic                       clip;
    } sat_t;

    // Distance of a tap from the center, limited to the outermost coefficient.
    function automatic int coef_sel(input int k);
        int d;
        d = (k > CENTER) ? (k - CENTER) : (CENTER - k);
        if (d > NUM_COEF - 1)
            d = NUM_COEF - 1;
        return d;
    endfunction

    function automatic sat_t sat_weight(input logic signed [CAL_W-1:0] v);
        sat_t r;
        if (v > CAL_W'(WEIGHT_MAX)) begin
            r.val  = WEIGHT_MAX;
            r.clip = 1'b1;
        end else if (v < CAL_W'(WEIGHT_MIN)) begin
            r.val  = WEIGHT_MIN;
            r.clip = 1'b1;
        end else begin
            r.val  = WEIGHT_W'(v);
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

### hdl/calibrated_symmetric_fir_filter.sv
// Top level: calibration, tap cell chain, rounding, output register and config registers.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | adc_sample, first_of_record
//  out     | out_valid / out_stall| filtered_weight, saturated
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A sample passes from its transfer through the calibration, tap and accumulate states,
// where the partial sum ripples once through the chain of tap cells, to the output register.
// The input is stalled from the transfer until the result is placed in the output register.
// A result waiting in the output register holds the next one only in its final state, ST_DONE.
// Reset clears the delay line, the coefficients and the calibration registers to zero.
`timescale 1ns / 1ps

module calibrated_symmetric_fir_filter (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [cfsf_pkg::SAMPLE_W-1:0]    adc_sample,
    input  logic                                    first_of_record,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [cfsf_pkg::WEIGHT_W-1:0]    filtered_weight,
    output logic                                    saturated,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [cfsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [cfsf_pkg::CFG_W-1:0]       cfg_data
);
    import cfsf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MULCAL = 3'd1;
    localparam logic [2:0] ST_SUMCAL = 3'd2;
    localparam logic [2:0] ST_WEIGHT = 3'd3;
    localparam logic [2:0] ST_TAPS   = 3'd4;
    localparam logic [2:0] ST_ACC    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;

    logic signed [COEF_W-1:0]   coef_reg [0:NUM_COEF-1];
    logic signed [GAIN_W-1:0]   cal_gain_reg;
    logic signed [WEIGHT_W-1:0] cal_offset_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       first_reg;
    logic signed [MLO_W-1:0]    mlo_reg;
    logic signed [MHI_W-1:0]    mhi_reg;
    logic signed [CAL_W-1:0]    prod_reg;
    logic                       cal_clip_reg;

    logic                       out_valid_reg;
    logic signed [WEIGHT_W-1:0] fw_reg;
    logic                       sat_reg;

    logic signed [MLO_W:0]      mlo_rnd;
    logic signed [CAL_W-1:0]    prod_next;
    sat_t                       cal_sat;
    logic signed [RND_W-1:0]    acc_rnd;
    sat_t                       filt_sat;
    logic                       out_free;
    logic                       emit;

    tap_ctl_t                   tap_ctl [0:TAP_COUNT-1];
    logic signed [WEIGHT_W-1:0] x_chain [0:TAP_COUNT-1];
    logic signed [ACC_W-1:0]    acc_chain [0:TAP_COUNT];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
                coef_reg[i] <= '0;
            cal_gain_reg   <= '0;
            cal_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index) inside
                REG_COEF_CENTER, REG_COEF_SIDE1, REG_COEF_SIDE2,
                REG_COEF_SIDE3, REG_COEF_SIDE4, REG_COEF_SIDE5:
                    coef_reg[cfg_index] <= cfg_data[COEF_W-1:0];
                REG_CAL_GAIN:
                    cal_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_CAL_OFFSET:
                    cal_offset_reg <= cfg_data[WEIGHT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign mlo_rnd   = (MLO_W+1)'(mlo_reg) + (MLO_W+1)'(1 << (FRAC_W - 1));
    assign prod_next = CAL_W'(mhi_reg) + CAL_W'($signed(mlo_rnd[MLO_W:FRAC_W]));
    assign cal_sat   = sat_weight(prod_reg - CAL_W'(cal_offset_reg));

    assign acc_rnd   = RND_W'(acc_chain[TAP_COUNT]) + RND_W'(1 << (FRAC_W - 1));
    assign filt_sat  = sat_weight(CAL_W'($signed(acc_rnd[RND_W-1:FRAC_W])));

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == ST_DONE) && out_free;
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_MULCAL;
            ST_MULCAL:
                state_next = ST_SUMCAL;
            ST_SUMCAL:
                state_next = ST_WEIGHT;
            ST_WEIGHT:
                state_next = ST_TAPS;
            ST_TAPS:
            begin
                cnt_next   = '0;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TAP_COUNT - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            sample_reg <= adc_sample;
            first_reg  <= first_of_record;
        end
        if (state_reg == ST_MULCAL)
        begin
            mlo_reg <= MLO_W'(sample_reg) * MLO_W'($signed({1'b0, cal_gain_reg[FRAC_W-1:0]}));
            mhi_reg <= MHI_W'(sample_reg) * MHI_W'($signed(cal_gain_reg[GAIN_W-1:FRAC_W]));
        end
        if (state_reg == ST_SUMCAL)
            prod_reg <= prod_next;
        if (state_reg == ST_WEIGHT)
            cal_clip_reg <= cal_sat.clip;
        if (emit)
        begin
            fw_reg  <= filt_sat.val;
            sat_reg <= filt_sat.clip || cal_clip_reg;
        end
    end

    assign acc_chain[0] = '0;

    for (genvar k = 0; k < TAP_COUNT; k++)
    begin : g_tap
        if (k == 0)
        begin : g_first
            assign tap_ctl[k].load  = (state_reg == ST_WEIGHT);
            assign tap_ctl[k].shift = 1'b0;
            cfsf_tap_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (tap_ctl[k]),
                .weight  (cal_sat.val),
                .x_prev  (cal_sat.val),
                .coef    (coef_reg[3'(coef_sel(k))]),
                .acc_in  (acc_chain[k]),
                .x_out   (x_chain[k]),
                .acc_out (acc_chain[k+1])
            );
        end
        else
        begin : g_rest
            assign tap_ctl[k].load  = (state_reg == ST_WEIGHT) && first_reg;
            assign tap_ctl[k].shift = emit;
            cfsf_tap_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (tap_ctl[k]),
                .weight  (cal_sat.val),
                .x_prev  (x_chain[k-1]),
                .coef    (coef_reg[3'(coef_sel(k))]),
                .acc_in  (acc_chain[k]),
                .x_out   (x_chain[k]),
                .acc_out (acc_chain[k+1])
            );
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_weight = fw_reg;
    assign saturated       = sat_reg;

endmodule

### hdl/cfsf_tap_cell.sv
// One filter tap cell: delay-line register, tap product and partial-sum stage.
`timescale 1ns / 1ps

module cfsf_tap_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cfsf_pkg::tap_ctl_t                     ctl,
    input  logic signed [cfsf_pkg::WEIGHT_W-1:0]   weight,
    input  logic signed [cfsf_pkg::WEIGHT_W-1:0]   x_prev,
    input  logic signed [cfsf_pkg::COEF_W-1:0]     coef,
    input  logic signed [cfsf_pkg::ACC_W-1:0]      acc_in,
    output logic signed [cfsf_pkg::WEIGHT_W-1:0]   x_out,
    output logic signed [cfsf_pkg::ACC_W-1:0]      acc_out
);
    import cfsf_pkg::*;

    logic signed [WEIGHT_W-1:0] x_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
        end
        else if (ctl.load)
        begin
            x_reg <= weight;
        end
        else if (ctl.shift)
        begin
            x_reg <= x_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(x_reg) * PROD_W'(coef);
        acc_reg  <= acc_in + ACC_W'(prod_reg);
    end

    assign x_out   = x_reg;
    assign acc_out = acc_reg;

endmodule

### hdl/cfsf_checker.sv
// Port-level checker for the filter top level and its bind statement.
`timescale 1ns / 1ps

module cfsf_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_stall,
    input logic signed [cfsf_pkg::SAMPLE_W-1:0]    adc_sample,
    input logic                                    first_of_record,
    input logic                                    out_valid,
    input logic                                    out_stall,
    input logic signed [cfsf_pkg::WEIGHT_W-1:0]    filtered_weight,
    input logic                                    saturated
);

    // A sample keeps the input stalled while its calibration runs.
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("input taken again while a sample is in progress");

    // A new result appears only when the block has returned to accepting input.
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result presented while the block is still busy");

    a_in_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(adc_sample) && $stable(first_of_record))
        else $error("stalled input transfer changed");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(filtered_weight) && $stable(saturated))
        else $error("stalled result changed");

endmodule

bind calibrated_symmetric_fir_filter cfsf_checker u_cfsf_checker (.*);

### tb/tb_calibrated_symmetric_fir_filter.sv
// Self-checking testbench for the calibrated symmetric FIR filter, with its own prediction.
`timescale 1ns / 1ps

module tb_calibrated_symmetric_fir_filter;
    import cfsf_pkg::*;

    localparam int HIST_DEPTH     = TAP_COUNT - 1;
    localparam int SETTLE_CYCLES  = 2 * (TAP_COUNT + 5) + 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int HOLD_AT        = 60;
    localparam int PHASE_ITEMS    = 150;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
        logic                       drain_first;
    } sample_t;

    logic                        clk             = 1'b0;
    logic                        rst_n           = 1'b0;
    logic                        in_valid        = 1'b0;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  adc_sample      = '0;
    logic                        first_of_record = 1'b0;
    logic                        out_valid;
    logic                        out_stall       = 1'b0;
    logic signed [WEIGHT_W-1:0]  filtered_weight;
    logic                        saturated;
    logic                        cfg_valid       = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index       = '0;
    logic [CFG_W-1:0]            cfg_data        = '0;

    logic signed [COEF_W-1:0]    coef_m [NUM_COEF];
    logic signed [GAIN_W-1:0]    gain_m;
    logic signed [WEIGHT_W-1:0]  offset_m;
    logic signed [WEIGHT_W-1:0]  history_m [HIST_DEPTH];

    sample_t     sample_queue [$];
    sat_t        weight_expect [$];
    sample_t     cur_item;
    sat_t        want;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned errors      = 0;
    int unsigned out_count   = 0;
    int unsigned hold_left   = 0;
    int unsigned quiet_count = 0;

    calibrated_symmetric_fir_filter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .adc_sample      (adc_sample),
        .first_of_record (first_of_record),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered_weight (filtered_weight),
        .saturated       (saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic sat_t clamp_weight(input logic signed [79:0] v);
        sat_t r;
        r.clip = 1'b1;
        if (v > 80'(WEIGHT_MAX))
            r.val = WEIGHT_MAX;
        else if (v < 80'(WEIGHT_MIN))
            r.val = WEIGHT_MIN;
        else
        begin
            r.val  = v[WEIGHT_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Calibrates a sample, fills history on first, filters it and advances the delay line.
    function automatic sat_t predict_weight(input logic signed [SAMPLE_W-1:0] s,
                                            input logic first);
        logic signed [79:0] se, ge, acc, xe, ce;
        sat_t               w, y;
        int                 k, d;
        se  = 80'(s);
        ge  = 80'(gain_m);
        w   = clamp_weight(((se * ge + 80'sd32768) >>> FRAC_W) - 80'(offset_m));
        if (first)
            for (k = 0; k < HIST_DEPTH; k++)
                history_m[k] = w.val;
        acc = '0;
        for (k = 0; k < TAP_COUNT; k++)
        begin
            if (k == 0)
                xe = 80'(w.val);
            else
                xe = 80'(history_m[k-1]);
            d = (k > CENTER) ? (k - CENTER) : (CENTER - k);
            if (d > NUM_COEF - 1)
                d = NUM_COEF - 1;
            ce  = 80'(coef_m[d]);
            acc = acc + xe * ce;
        end
        y      = clamp_weight((acc + 80'sd32768) >>> FRAC_W);
        y.clip = y.clip | w.clip;
        for (k = HIST_DEPTH - 1; k > 0; k--)
            history_m[k] = history_m[k-1];
        history_m[0] = w.val;
        return y;
    endfunction

    function automatic logic [CFG_W-1:0] rand40();
        return {8'($urandom), $urandom};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [SAMPLE_W-1:0] s;
        s = $urandom;
        if ($urandom_range(3) != 0)
            s = s >>> $urandom_range(28, 6);
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid        <= 1'b0;
            adc_sample      <= '0;
            first_of_record <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                weight_expect.push_back(predict_weight(cur_item.sample, cur_item.first));
            if (!in_valid || !in_stall)
            begin
                if (sample_queue.size() == 0 || $urandom_range(99) < idle_pct ||
                    (sample_queue[0].drain_first && weight_expect.size() != 0))
                    in_valid <= 1'b0;
                else
                begin
                    cur_item = sample_queue.pop_front();
                    adc_sample      <= cur_item.sample;
                    first_of_record <= cur_item.first;
                    in_valid        <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (out_count == HOLD_AT)
                    hold_left = HOLD_CYCLES;
                out_count = out_count + 1;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (weight_expect.size() == 0)
            begin
                $display("%0t: result with none expected, filtered_weight %0d saturated %0b",
                         $time, filtered_weight, saturated);
                errors++;
            end
            else
            begin
                want = weight_expect.pop_front();
                if (filtered_weight !== want.val)
                begin
                    $display("%0t: filtered_weight expected %0d actual %0d",
                             $time, want.val, filtered_weight);
                    errors++;
                end
                if (saturated !== want.clip)
                begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.clip, saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("tb_calibrated_symmetric_fir_filter: done, errors");
            $finish;
        end
    end

    task automatic drain();
        while (sample_queue.size() > 0 || in_valid || weight_expect.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CAL_GAIN:   gain_m   = value;
            REG_CAL_OFFSET: offset_m = value;
            default:        coef_m[idx] = value[COEF_W-1:0];
        endcase
    endtask

    // Coefficient 0 is the center tap and sits in the low bits of coefs.
    task automatic load_config(input logic [NUM_COEF*COEF_W-1:0] coefs,
                               input logic [CFG_W-1:0] gain,
                               input logic [CFG_W-1:0] offset);
        drain();
        for (int i = 0; i < NUM_COEF; i++)
            write_reg(REG_COEF_CENTER + CFG_IDX_W'(i),
                      {22'($urandom), coefs[i*COEF_W +: COEF_W]});
        write_reg(REG_CAL_GAIN, gain);
        write_reg(REG_CAL_OFFSET, offset);
        @(negedge clk);
    endtask

    task automatic add_item(input logic signed [SAMPLE_W-1:0] s, input logic first,
                            input logic drain_first);
        sample_queue.push_back('{s, first, drain_first});
    endtask

    task automatic random_phase(input int unsigned idle, input int unsigned stall,
                                input bit wide);
        logic [NUM_COEF*COEF_W-1:0] coefs;
        logic [CFG_W-1:0]           g, o;
        logic                       first;
        int                         left, run;
        for (int i = 0; i < NUM_COEF; i++)
            coefs[i*COEF_W +: COEF_W] = 18'($urandom);
        g = rand40();
        o = rand40();
        if (!wide)
        begin
            g = $signed(g) >>> $urandom_range(36, 4);
            o = $signed(o) >>> $urandom_range(30, 8);
        end
        load_config(coefs, g, o);
        idle_pct  = idle;
        stall_pct = stall;
        left      = PHASE_ITEMS;
        while (left > 0)
        begin
            run = $urandom_range(40, 1);
            for (int j = 0; j < run && left > 0; j++)
            begin
                first = (j == 0);
                if ($urandom_range(19) == 0)
                    first = 1'($urandom_range(1));
                add_item(rand_sample(), first,
                         (left == PHASE_ITEMS / 2) || ($urandom_range(149) == 0));
                left--;
            end
        end
    endtask

    initial
    begin
        gain_m   = '0;
        offset_m = '0;
        for (int i = 0; i < NUM_COEF; i++)
            coef_m[i] = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
            history_m[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Gain of 65536 and unity center tap; the first item runs on the zeros left by reset.
        load_config({{5{18'd0}}, 18'd65536}, 40'h01_0000_0000, 40'd0);
        add_item(32'sd1000, 1'b0, 1'b0);
        add_item(32'sh7FFF_FFFF, 1'b0, 1'b0);
        add_item(32'sh8000_0000, 1'b0, 1'b0);
        add_item(-32'sd1, 1'b0, 1'b0);
        add_item(32'sd1, 1'b1, 1'b0);
        add_item(32'sd0, 1'b0, 1'b0);

        // Largest gain and coefficients with the most negative offset, then the reverse.
        load_config({NUM_COEF{18'h1FFFF}}, 40'h7F_FFFF_FFFF, 40'h80_0000_0000);
        add_item(32'sh7FFF_FFFF, 1'b1, 1'b0);
        add_item(32'sd0, 1'b0, 1'b0);
        add_item(32'sh8000_0000, 1'b0, 1'b0);
        load_config({NUM_COEF{18'h20000}}, 40'h80_0000_0000, 40'h7F_FFFF_FFFF);
        add_item(32'sh7FFF_FFFF, 1'b1, 1'b0);
        add_item(32'sh8000_0000, 1'b0, 1'b0);
        add_item(32'sd0, 1'b0, 1'b0);

        // Zero scale gives zero weights.
        load_config({6{18'($urandom)}}, 40'd0, 40'd0);
        add_item(rand_sample(), 1'b1, 1'b0);

        // An impulse walks through every tap, so each coefficient shows up in turn.
        load_config({18'd6, 18'd5, 18'd4, 18'd3, 18'd2, 18'd1}, 40'h01_0000_0000, 40'd0);
        add_item(32'sd0, 1'b1, 1'b0);
        add_item(32'sd5000, 1'b0, 1'b0);
        for (int i = 0; i < HIST_DEPTH; i++)
            add_item(32'sd0, 1'b0, 1'b0);

        random_phase(0, 0, 1'b0);
        random_phase(0, 0, 1'b1);
        random_phase(69, 0, 1'b0);
        random_phase(69, 0, 1'b1);
        random_phase(0, 69, 1'b0);
        random_phase(0, 69, 1'b1);
        random_phase(24, 24, 1'b0);
        random_phase(24, 24, 1'b1);

        drain();
        if (errors == 0 && weight_expect.size() == 0)
            $display("tb_calibrated_symmetric_fir_filter: done, clean");
        else
            $display("tb_calibrated_symmetric_fir_filter: done, errors");
        $finish;
    end

endmodule
